/* rtl/cdir_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache directory package
// Shared constants, configuration codes, record types and FSM states of the
// set-associative cache directory.
// ----------------------------------------------------------------------------
package cdir_pkg;

   localparam int MAX_WAYS   = 8;
   localparam int MAX_SETS   = 256;
   localparam int COUNT_BITS = 16;
   localparam int AGE_BITS   = 8;
   localparam int ADDR_BITS  = 32;
   localparam int TAG_BITS   = 30;
   localparam int LFSR_BITS  = 16;
   localparam int WAY_BITS   = 3;
   localparam int WAYS_BITS  = 4;
   localparam int SET_BITS   = $clog2(MAX_SETS);
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 4;

   localparam logic [LFSR_BITS-1:0] LFSR_MASK  = 16'hB400;
   localparam logic [LFSR_BITS-1:0] LFSR_SEED  = 16'h0001;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [AGE_BITS-1:0] AGE_MAX     = '1;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_WAYS_IN_USE     = 3'd0,
      CSR_OFFSET_BITS     = 3'd1,
      CSR_INDEX_BITS      = 3'd2,
      CSR_REPLACE_MODE    = 3'd3,
      CSR_WRITE_BACK_MODE = 3'd4
   } csr_index_type;

   // Replacement policy codes.
   localparam logic [1:0] REPL_LFU = 2'd0;
   localparam logic [1:0] REPL_LRU = 2'd1;

   // Clamped configuration seen by the back end.
   typedef struct packed {
      logic [WAYS_BITS-1:0] ways;
      logic [2:0]           offset_bits;
      logic [3:0]           index_bits;
      logic [1:0]           replace_mode;
      logic                 write_back_mode;
   } cfg_type;

   // One classified access waiting in the queue.
   typedef struct packed {
      logic                bypass;
      logic                write;
      logic [SET_BITS-1:0] set;
      logic [TAG_BITS-1:0] tag;
   } job_type;

   // One directory row: every way of a set.
   typedef struct packed {
      logic [MAX_WAYS-1:0]                 valid;
      logic [MAX_WAYS-1:0]                 dirty;
      logic [MAX_WAYS-1:0][TAG_BITS-1:0]   tag;
      logic [MAX_WAYS-1:0][COUNT_BITS-1:0] count;
      logic [MAX_WAYS-1:0][AGE_BITS-1:0]   age;
   } row_type;

   // Result beat payload.
   typedef struct packed {
      logic                 hit;
      logic [WAY_BITS-1:0]  way;
      logic                 fill_needed;
      logic                 writeback_needed;
      logic [ADDR_BITS-1:0] victim_address;
      logic                 store_through;
      logic                 bypass;
   } result_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_EVAL,
      BK_MOD,
      BK_COMMIT
   } back_state_type;

endpackage

/* rtl/cdir_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Access request channel
// Valid/ready channel carrying one cache access per beat.
// ----------------------------------------------------------------------------
interface cdir_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] address;

   modport source (output valid, command, address, input ready);
   modport sink   (input valid, command, address, output ready);
endinterface

/* rtl/cdir_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Access result channel
// Valid/ready channel carrying one directory result per beat.
// ----------------------------------------------------------------------------
interface cdir_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [2:0]  way;
   logic        fill_needed;
   logic        writeback_needed;
   logic [31:0] victim_address;
   logic        store_through;
   logic        bypass;

   modport source (output valid, hit, way, fill_needed, writeback_needed,
                   victim_address, store_through, bypass, input ready);
   modport sink   (input valid, hit, way, fill_needed, writeback_needed,
                   victim_address, store_through, bypass, output ready);
endinterface

/* rtl/set_assoc_cache_directory.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative cache directory
// Tag directory and LFU/LRU/random replacement engine with allocate-on-write.
// ----------------------------------------------------------------------------
// An access passes the back end as row read, evaluate and commit; a miss
// with every way valid under random replacement adds a bit-serial modulo
// of the LFSR value by the ways in use. Bypass accesses skip evaluation.
// The set row memory has one read and one write port, so the back end
// handles one access at a time while a two-entry queue keeps accepting
// requests. No clearing pass is needed after reset: one valid flag per
// set makes unwritten rows read as cleared.
module set_assoc_cache_directory (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [cdir_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [cdir_pkg::CSR_DATA_BITS-1:0] csr_write_data,
   cdir_req_if.sink                          req,
   cdir_rsp_if.source                        rsp
);
   import cdir_pkg::*;

   cfg_type    cfg;
   job_type    push_job, pop_job;
   logic       push, queue_full, pop, pop_valid;
   result_type rsp_data;

   cdir_front u_front (
      .clock, .reset, .csr_write_enable, .csr_index, .csr_write_data,
      .req_valid   (req.valid),
      .req_ready   (req.ready),
      .req_command (req.command),
      .req_address (req.address),
      .queue_full, .push, .push_job, .cfg
   );

   cdir_queue u_queue (
      .clock, .reset, .push, .push_job,
      .full (queue_full),
      .pop, .pop_valid, .pop_job
   );

   cdir_back u_back (
      .clock, .reset, .cfg,
      .job_valid (pop_valid),
      .job       (pop_job),
      .pop,
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .rsp_data
   );

   assign rsp.hit              = rsp_data.hit;
   assign rsp.way              = rsp_data.way;
   assign rsp.fill_needed      = rsp_data.fill_needed;
   assign rsp.writeback_needed = rsp_data.writeback_needed;
   assign rsp.victim_address   = rsp_data.victim_address;
   assign rsp.store_through    = rsp_data.store_through;
   assign rsp.bypass           = rsp_data.bypass;

`ifndef NO_ASSERTIONS
   // A bypassed beat carries no directory outcome.
   a_bypass_clean: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.bypass |-> !rsp.hit && !rsp.fill_needed && !rsp.writeback_needed)
      else $error("bypass beat with directory outcome");

   // A write-back only happens on an eviction fill.
   a_wb_on_fill: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.writeback_needed |-> rsp.fill_needed && !rsp.hit)
      else $error("write-back without fill");

   // The queue only pops when the back end accepts a job.
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("pop from empty queue");
`endif

endmodule

/* rtl/cdir_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache directory front end
// Holds the configuration registers, clamps them, and splits each accepted
// address into set and tag for the queue.
// ----------------------------------------------------------------------------
module cdir_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [cdir_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [cdir_pkg::CSR_DATA_BITS-1:0] csr_write_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_command,
   input  logic [cdir_pkg::ADDR_BITS-1:0]    req_address,
   input  logic                              queue_full,
   output logic                              push,
   output cdir_pkg::job_type                 push_job,
   output cdir_pkg::cfg_type                 cfg
);
   import cdir_pkg::*;

   logic [3:0] ways_ff, ways_in;
   logic [2:0] offset_ff, offset_in;
   logic [3:0] index_ff, index_in;
   logic [1:0] mode_ff, mode_in;
   logic       wbm_ff, wbm_in;
   logic [5:0] tag_shift;
   logic [ADDR_BITS-1:0] set_full;

   // Register writes.
   always_comb begin
      ways_in   = ways_ff;
      offset_in = offset_ff;
      index_in  = index_ff;
      mode_in   = mode_ff;
      wbm_in    = wbm_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_WAYS_IN_USE:     ways_in   = csr_write_data[3:0];
            CSR_OFFSET_BITS:     offset_in = csr_write_data[2:0];
            CSR_INDEX_BITS:      index_in  = csr_write_data[3:0];
            CSR_REPLACE_MODE:    mode_in   = csr_write_data[1:0];
            CSR_WRITE_BACK_MODE: wbm_in    = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ways_ff   <= 4'd0;
         offset_ff <= 3'd2;
         index_ff  <= 4'd0;
         mode_ff   <= REPL_LRU;
         wbm_ff    <= 1'b0;
      end else begin
         ways_ff   <= ways_in;
         offset_ff <= offset_in;
         index_ff  <= index_in;
         mode_ff   <= mode_in;
         wbm_ff    <= wbm_in;
      end
   end

   // Out-of-range settings saturate.
   always_comb begin
      cfg.ways = (ways_ff > WAYS_BITS'(MAX_WAYS)) ? WAYS_BITS'(MAX_WAYS) : ways_ff;
      cfg.offset_bits = (offset_ff < 3'd2) ? 3'd2 : (offset_ff > 3'd5) ? 3'd5 : offset_ff;
      cfg.index_bits = (index_ff > 4'(SET_BITS)) ? 4'(SET_BITS) : index_ff;
      cfg.replace_mode = mode_ff;
      cfg.write_back_mode = wbm_ff;
   end

   // Address split.
   assign tag_shift = 6'(cfg.offset_bits) + 6'(cfg.index_bits);
   assign set_full  = (req_address >> cfg.offset_bits)
                      & ((ADDR_BITS'(1) << cfg.index_bits) - ADDR_BITS'(1));

   always_comb begin
      push_job.bypass = (cfg.ways == '0);
      push_job.write  = req_command;
      push_job.set    = set_full[SET_BITS-1:0];
      push_job.tag    = TAG_BITS'(req_address >> tag_shift);
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

endmodule

/* rtl/cdir_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache directory job queue
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module cdir_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cdir_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output cdir_pkg::job_type pop_job
);
   import cdir_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_job   = entry_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_in    = do_push ? !wr_ff : wr_ff;
      rd_in    = do_pop ? !rd_ff : rd_ff;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_job;
      end
   end

endmodule

/* rtl/cdir_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache directory back end
// Reads the set row, finds hit or victim, runs the random pick when needed,
// then writes the updated row (not on bypass) and registers the result beat.
// ----------------------------------------------------------------------------
module cdir_back (
   input  logic                clock,
   input  logic                reset,
   input  cdir_pkg::cfg_type   cfg,
   input  logic                job_valid,
   input  cdir_pkg::job_type   job,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cdir_pkg::result_type rsp_data
);
   import cdir_pkg::*;

   back_state_type state_ff, state_in;
   row_type        mem [MAX_SETS];
   row_type        rd_ff;
   logic           rdv_ff;
   logic [MAX_SETS-1:0] rowv_ff;
   job_type        job_ff;
   logic           hit_ff, fill_ff, evict_ff;
   logic [WAY_BITS-1:0] way_ff;
   logic [LFSR_BITS-1:0] lfsr_ff, lfsr_next, div_ff;
   logic [WAY_BITS-1:0] rem_ff;
   logic [3:0]     step_ff;
   logic           rsp_valid_ff;
   result_type     rsp_ff;

   row_type        row, new_row;
   logic           hit_found, inv_found;
   logic [WAY_BITS-1:0] hit_way, inv_way, lfu_way, lru_way, eval_way;
   logic           need_random;
   logic [WAY_BITS:0] trial;
   logic [WAY_BITS-1:0] rem_next;
   logic           mod_done, out_free, commit;
   logic           wb;
   logic [5:0]     tag_shift;
   logic [ADDR_BITS-1:0] victim;

   // A row never written reads as cleared.
   assign row = rdv_ff ? rd_ff : '0;

   // Hit and invalid-way search over the active ways.
   always_comb begin
      hit_found = 1'b0;
      inv_found = 1'b0;
      hit_way   = '0;
      inv_way   = '0;
      for (int j = 0; j < MAX_WAYS; j++) begin
         if (WAYS_BITS'(j) < cfg.ways) begin
            if (!hit_found && row.valid[j] && row.tag[j] == job_ff.tag) begin
               hit_found = 1'b1;
               hit_way   = WAY_BITS'(j);
            end
            if (!inv_found && !row.valid[j]) begin
               inv_found = 1'b1;
               inv_way   = WAY_BITS'(j);
            end
         end
      end
   end

   // Least-used and oldest way, ties to the lowest way.
   always_comb begin
      lfu_way = '0;
      lru_way = '0;
      for (int j = 1; j < MAX_WAYS; j++) begin
         if (WAYS_BITS'(j) < cfg.ways) begin
            if (row.count[j] < row.count[lfu_way]) lfu_way = WAY_BITS'(j);
            if (row.age[j] > row.age[lru_way])     lru_way = WAY_BITS'(j);
         end
      end
   end

   always_comb begin
      need_random = !hit_found && !inv_found && cfg.replace_mode != REPL_LFU
                    && cfg.replace_mode != REPL_LRU;
      if (hit_found)                          eval_way = hit_way;
      else if (inv_found)                     eval_way = inv_way;
      else if (cfg.replace_mode == REPL_LFU)  eval_way = lfu_way;
      else                                    eval_way = lru_way;
   end

   assign lfsr_next = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? LFSR_MASK : '0);

   // One remainder bit per cycle: LFSR value modulo the active ways.
   always_comb begin
      trial    = {rem_ff, div_ff[LFSR_BITS-1]};
      rem_next = (trial >= (WAY_BITS+1)'(cfg.ways)) ?
                 WAY_BITS'(trial - (WAY_BITS+1)'(cfg.ways)) : trial[WAY_BITS-1:0];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:   if (job_valid) state_in = job.bypass ? BK_COMMIT : BK_EVAL;
         BK_EVAL:   state_in = need_random ? BK_MOD : BK_COMMIT;
         BK_MOD:    if (mod_done) state_in = BK_COMMIT;
         BK_COMMIT: if (out_free) state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   // FSM outputs.
   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      pop      = (state_ff == BK_IDLE) && job_valid;
      mod_done = (state_ff == BK_MOD) && (step_ff == 4'd15);
      commit   = (state_ff == BK_COMMIT) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= BK_IDLE;
      else       state_ff <= state_in;
   end

   // Row update for the chosen way.
   always_comb begin
      new_row = row;
      if (fill_ff) begin
         new_row.valid[way_ff] = 1'b1;
         new_row.dirty[way_ff] = 1'b0;
         new_row.tag[way_ff]   = job_ff.tag;
         new_row.count[way_ff] = COUNT_BITS'(1);
      end else if (row.count[way_ff] != COUNT_MAX) begin
         new_row.count[way_ff] = row.count[way_ff] + COUNT_BITS'(1);
      end
      for (int j = 0; j < MAX_WAYS; j++) begin
         if (WAYS_BITS'(j) < cfg.ways) begin
            if (WAY_BITS'(j) == way_ff)      new_row.age[j] = '0;
            else if (row.age[j] != AGE_MAX)  new_row.age[j] = row.age[j] + AGE_BITS'(1);
         end
      end
      if (job_ff.write && cfg.write_back_mode) new_row.dirty[way_ff] = 1'b1;
   end

   assign wb        = fill_ff && evict_ff && cfg.write_back_mode && row.dirty[way_ff];
   assign tag_shift = 6'(cfg.offset_bits) + 6'(cfg.index_bits);
   assign victim    = (ADDR_BITS'(row.tag[way_ff]) << tag_shift)
                      | (ADDR_BITS'(job_ff.set) << cfg.offset_bits);

   // Row memory, row-valid marks and working registers.
   always_ff @(posedge clock) begin
      if (pop) begin
         rd_ff  <= mem[job.set];
         job_ff <= job;
      end
      if (commit && !job_ff.bypass) begin
         mem[job_ff.set] <= new_row;
      end
      if (state_ff == BK_EVAL) begin
         hit_ff   <= hit_found;
         fill_ff  <= !hit_found;
         evict_ff <= !hit_found && !inv_found;
         way_ff   <= eval_way;
         div_ff   <= lfsr_next;
         rem_ff   <= '0;
         step_ff  <= '0;
      end
      if (state_ff == BK_MOD) begin
         rem_ff  <= rem_next;
         div_ff  <= div_ff << 1;
         step_ff <= step_ff + 4'd1;
         if (mod_done) way_ff <= rem_next;
      end
      if (commit) begin
         rsp_ff.bypass           <= job_ff.bypass;
         rsp_ff.hit              <= !job_ff.bypass && hit_ff;
         rsp_ff.way              <= job_ff.bypass ? '0 : way_ff;
         rsp_ff.fill_needed      <= !job_ff.bypass && fill_ff;
         rsp_ff.writeback_needed <= !job_ff.bypass && wb;
         rsp_ff.victim_address   <= (!job_ff.bypass && wb) ? victim : '0;
         rsp_ff.store_through    <= !job_ff.bypass && job_ff.write && !cfg.write_back_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rowv_ff      <= '0;
         rdv_ff       <= 1'b0;
         lfsr_ff      <= LFSR_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) rdv_ff <= rowv_ff[job.set];
         if (commit && !job_ff.bypass) rowv_ff[job_ff.set] <= 1'b1;
         if (state_ff == BK_EVAL && need_random) lfsr_ff <= lfsr_next;
         if (commit)         rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
